@@ design/matrix_inverse_3x3_defines.svh @@
// Assertion macros for the 3x3 matrix inverse checker.
// Used by mi3_checker only; expects clk and rst in scope.
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// same-cycle implication, masked during reset
`define MI3_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mi3 check failed");

// next-cycle implication, masked during reset
`define MI3_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mi3 check failed");

// next-cycle implication that also holds across reset
`define MI3_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mi3 check failed");

`endif

@@ design/mi3_pkg.sv @@
// Types and fixed widths for the 3x3 matrix inverse.
// No dependencies; imported by every module of the block.
package mi3_pkg;

  localparam int ELEM_W = 32;
  localparam int COF_W  = 2 * ELEM_W + 1;   // exact 2x2 cofactor
  localparam int DET_W  = 3 * ELEM_W + 3;   // exact determinant
  localparam int DEN_W  = DET_W + 1;        // twice |det|
  localparam int THR_W  = 31;

  typedef logic signed [ELEM_W-1:0]   elem_t;
  typedef logic signed [2*ELEM_W-1:0] prod_t;
  typedef logic signed [2*ELEM_W+1:0] pprod_t;
  typedef logic signed [COF_W-1:0]    cof_t;
  typedef logic signed [DET_W-1:0]    det_t;
  typedef cof_t  [8:0] adj_t;
  typedef elem_t [2:0] row_t;

  typedef struct packed {
    elem_t a00; elem_t a01; elem_t a02;
    elem_t a10; elem_t a11; elem_t a12;
    elem_t a20; elem_t a21; elem_t a22;
  } mat_t;

  typedef struct packed {
    elem_t inv_00; elem_t inv_01; elem_t inv_02;
    elem_t inv_10; elem_t inv_11; elem_t inv_12;
    elem_t inv_20; elem_t inv_21; elem_t inv_22;
    logic  singular;
  } inv_t;

  // adj[k] = a[p]*a[q] - a[s]*a[t], element indexes row-major
  localparam int COF_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

endpackage

@@ design/mi3_cof.sv @@
// Cofactor stages: 18 products, then nine exact 2x2 differences.
// Depends on mi3_pkg.
module mi3_cof import mi3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic valid_up,
  output logic stall_up,
  input  mat_t mat,
  output logic valid_dn,
  input  logic stall_dn,
  output adj_t adj,
  output row_t row0
);

  localparam int NS = 2;

  elem_t a [9];
  logic [NS-1:0] v;
  logic [NS-1:0] ld;
  prod_t pp [9];
  prod_t pq [9];
  row_t  row_s1;

  assign a[0] = mat.a00; assign a[1] = mat.a01; assign a[2] = mat.a02;
  assign a[3] = mat.a10; assign a[4] = mat.a11; assign a[5] = mat.a12;
  assign a[6] = mat.a20; assign a[7] = mat.a21; assign a[8] = mat.a22;

  always_comb begin
    ld[NS-1] = !v[NS-1] || !stall_dn;
    for (int j = NS - 2; j >= 0; j--) ld[j] = !v[j] || ld[j+1];
  end

  assign stall_up = !ld[0];
  assign valid_dn = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= valid_up;
      if (ld[1]) v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int k = 0; k < 9; k++) begin
        pp[k] <= prod_t'(a[COF_IDX[k][0]]) * prod_t'(a[COF_IDX[k][1]]);
        pq[k] <= prod_t'(a[COF_IDX[k][2]]) * prod_t'(a[COF_IDX[k][3]]);
      end
      row_s1 <= {a[2], a[1], a[0]};
    end
    if (ld[1]) begin
      for (int k = 0; k < 9; k++) adj[k] <= cof_t'(pp[k]) - cof_t'(pq[k]);
      row0 <= row_s1;
    end
  end

endmodule

@@ design/mi3_det.sv @@
// Determinant stages: split partial products, term assembly, 3-way sum.
// Depends on mi3_pkg; the adjugate rides along unchanged.
module mi3_det import mi3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic valid_up,
  output logic stall_up,
  input  adj_t adj_in,
  input  row_t row0,
  output logic valid_dn,
  input  logic stall_dn,
  output adj_t adj,
  output det_t det
);

  localparam int NS = 3;

  logic [NS-1:0] v;
  logic [NS-1:0] ld;
  pprod_t pl [3];
  pprod_t ph [3];
  det_t   term [3];
  adj_t   adj_s1;
  adj_t   adj_s2;

  always_comb begin
    ld[NS-1] = !v[NS-1] || !stall_dn;
    for (int j = NS - 2; j >= 0; j--) ld[j] = !v[j] || ld[j+1];
  end

  assign stall_up = !ld[0];
  assign valid_dn = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= valid_up;
      if (ld[1]) v[1] <= v[0];
      if (ld[2]) v[2] <= v[1];
    end
  end

  // det = a0*adj0 + a1*adj3 + a2*adj6; cofactor cut into low and high halves
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        pl[i] <= pprod_t'(row0[i]) * pprod_t'($signed({1'b0, adj_in[3*i][ELEM_W-1:0]}));
        ph[i] <= pprod_t'(row0[i]) * pprod_t'($signed(adj_in[3*i][COF_W-1:ELEM_W]));
      end
      adj_s1 <= adj_in;
    end
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) term[i] <= (det_t'(ph[i]) <<< ELEM_W) + det_t'(pl[i]);
      adj_s2 <= adj_s1;
    end
    if (ld[2]) begin
      det <= term[0] + term[1] + term[2];
      adj <= adj_s2;
    end
  end

endmodule

@@ design/mi3_prep.sv @@
// Magnitudes, singular test and divider operands with rounding bias.
// Depends on mi3_pkg.
module mi3_prep import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int NUM_W = 2 * FRAC_BITS + COF_W + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid_up,
  output logic                         stall_up,
  input  adj_t                         adj,
  input  det_t                         det,
  input  logic [THR_W-1:0]             thr,
  output logic                         valid_dn,
  input  logic                         stall_dn,
  output logic [8:0][NUM_W-1:0]        num,
  output logic [DEN_W-1:0]             den,
  output logic [8:0]                   neg,
  output logic                         sing
);

  localparam int NS = 2;
  localparam int LIM_W = ((DET_W > THR_W + 2 * FRAC_BITS) ? DET_W
                                                          : THR_W + 2 * FRAC_BITS) + 1;

  logic [NS-1:0] v;
  logic [NS-1:0] ld;
  logic [COF_W-1:0] an [9];
  logic [DET_W-1:0] ad;
  logic [8:0]       neg_s1;

  always_comb begin
    ld[NS-1] = !v[NS-1] || !stall_dn;
    for (int j = NS - 2; j >= 0; j--) ld[j] = !v[j] || ld[j+1];
  end

  assign stall_up = !ld[0];
  assign valid_dn = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= valid_up;
      if (ld[1]) v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int k = 0; k < 9; k++) begin
        an[k]     <= adj[k][COF_W-1] ? COF_W'(-adj[k]) : COF_W'(adj[k]);
        neg_s1[k] <= adj[k][COF_W-1] ^ det[DET_W-1];
      end
      ad <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
    end
    if (ld[1]) begin
      // round half away: (|adj| * 2^(2F+1) + |det|) / (2 |det|)
      for (int k = 0; k < 9; k++)
        num[k] <= (NUM_W'(an[k]) << (2 * FRAC_BITS + 1)) + NUM_W'(ad);
      den  <= {ad, 1'b0};
      neg  <= neg_s1;
      sing <= (ad == '0) || (LIM_W'(ad) < (LIM_W'(thr) << (2 * FRAC_BITS)));
    end
  end

endmodule

@@ design/mi3_div.sv @@
// Nine-lane restoring divider, one quotient bit per stage, then saturation and singular zeroing.
// Depends on mi3_pkg.
module mi3_div import mi3_pkg::*; #(
  parameter int NUM_W = 100
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid_up,
  output logic                  stall_up,
  input  logic [8:0][NUM_W-1:0] num,
  input  logic [DEN_W-1:0]      den,
  input  logic [8:0]            neg,
  input  logic                  sing,
  output logic                  valid_dn,
  input  logic                  stall_dn,
  output inv_t                  res
);

  localparam int RW = (NUM_W > DEN_W + ELEM_W) ? NUM_W : DEN_W + ELEM_W;
  localparam int NS = ELEM_W + 2;
  localparam logic [ELEM_W:0] MAG_MAX = (ELEM_W + 1)'(1) << (ELEM_W - 1);

  logic [NS-1:0] v;
  logic [NS-1:0] ld;
  logic [RW-1:0]     rem  [ELEM_W+1][9];
  logic [ELEM_W-1:0] quo  [ELEM_W+1][9];
  logic [8:0]        ovf  [ELEM_W+1];
  logic [DEN_W-1:0]  den_s [ELEM_W+1];
  logic [8:0]        neg_s [ELEM_W+1];
  logic [ELEM_W:0]   sing_s;
  elem_t             lane [9];

  always_comb begin
    ld[NS-1] = !v[NS-1] || !stall_dn;
    for (int j = NS - 2; j >= 0; j--) ld[j] = !v[j] || ld[j+1];
  end

  assign stall_up = !ld[0];
  assign valid_dn = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= valid_up;
      for (int j = 1; j < NS; j++) if (ld[j]) v[j] <= v[j-1];
    end
  end

  // quotient at or above 2^ELEM_W saturates whatever the sign
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int k = 0; k < 9; k++) begin
        rem[0][k] <= RW'(num[k]);
        quo[0][k] <= '0;
        ovf[0][k] <= RW'(num[k]) >= (RW'(den) << ELEM_W);
      end
      den_s[0]  <= den;
      neg_s[0]  <= neg;
      sing_s[0] <= sing;
    end
  end

  for (genvar g = 1; g <= ELEM_W; g++) begin : g_bit
    localparam int B = ELEM_W - g;
    always_ff @(posedge clk) begin
      if (ld[g]) begin
        for (int k = 0; k < 9; k++) begin
          if (rem[g-1][k] >= (RW'(den_s[g-1]) << B)) begin
            rem[g][k] <= rem[g-1][k] - (RW'(den_s[g-1]) << B);
            quo[g][k] <= quo[g-1][k] | (ELEM_W'(1) << B);
          end else begin
            rem[g][k] <= rem[g-1][k];
            quo[g][k] <= quo[g-1][k];
          end
        end
        ovf[g]    <= ovf[g-1];
        den_s[g]  <= den_s[g-1];
        neg_s[g]  <= neg_s[g-1];
        sing_s[g] <= sing_s[g-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (sing_s[ELEM_W]) begin
        lane[k] = '0;
      end else if (neg_s[ELEM_W][k]) begin
        if (ovf[ELEM_W][k] || ({1'b0, quo[ELEM_W][k]} > MAG_MAX))
          lane[k] = elem_t'(MAG_MAX);
        else
          lane[k] = elem_t'(-{1'b0, quo[ELEM_W][k]});
      end else begin
        if (ovf[ELEM_W][k] || ({1'b0, quo[ELEM_W][k]} >= MAG_MAX))
          lane[k] = elem_t'(MAG_MAX - 1'b1);
        else
          lane[k] = elem_t'(quo[ELEM_W][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      res.inv_00 <= lane[0]; res.inv_01 <= lane[1]; res.inv_02 <= lane[2];
      res.inv_10 <= lane[3]; res.inv_11 <= lane[4]; res.inv_12 <= lane[5];
      res.inv_20 <= lane[6]; res.inv_21 <= lane[7]; res.inv_22 <= lane[8];
      res.singular <= sing_s[ELEM_W];
    end
  end

endmodule

@@ design/matrix_inverse_3x3.sv @@
// 3x3 fixed-point matrix inverse by adjugate and exact long division.
// An accepted matrix passes through the cofactor, determinant, prep and divider
// stages in order; the divider resolves one quotient bit per stage in all nine lanes.
// Throughput: one matrix per cycle while inv_stall is low; every stage holds its beat under stall.
// Reset: valid bits cleared, singular_threshold back to 1.
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             mat_valid,
  output logic             mat_stall,
  input  mat_t             mat,
  output logic             inv_valid,
  input  logic             inv_stall,
  output inv_t             inv,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int NUM_W = ((COF_W + 2 * FRAC_BITS + 1 > DET_W) ? COF_W + 2 * FRAC_BITS + 1
                                                            : DET_W) + 1;

  logic [THR_W-1:0] singular_threshold;

  logic cof_valid, cof_stall;
  adj_t cof_adj;
  row_t cof_row0;
  logic det_valid, det_stall;
  adj_t det_adj;
  det_t det_val;
  logic prep_valid, prep_stall;
  logic [8:0][NUM_W-1:0] prep_num;
  logic [DEN_W-1:0]      prep_den;
  logic [8:0]            prep_neg;
  logic                  prep_sing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      singular_threshold <= THR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      singular_threshold <= cfg_data;
    end
  end

  mi3_cof u_cof (
    .clk, .rst,
    .valid_up (mat_valid), .stall_up (mat_stall), .mat,
    .valid_dn (cof_valid), .stall_dn (cof_stall),
    .adj (cof_adj), .row0 (cof_row0)
  );

  mi3_det u_det (
    .clk, .rst,
    .valid_up (cof_valid), .stall_up (cof_stall),
    .adj_in (cof_adj), .row0 (cof_row0),
    .valid_dn (det_valid), .stall_dn (det_stall),
    .adj (det_adj), .det (det_val)
  );

  mi3_prep #(.FRAC_BITS (FRAC_BITS), .NUM_W (NUM_W)) u_prep (
    .clk, .rst,
    .valid_up (det_valid), .stall_up (det_stall),
    .adj (det_adj), .det (det_val), .thr (singular_threshold),
    .valid_dn (prep_valid), .stall_dn (prep_stall),
    .num (prep_num), .den (prep_den), .neg (prep_neg), .sing (prep_sing)
  );

  mi3_div #(.NUM_W (NUM_W)) u_div (
    .clk, .rst,
    .valid_up (prep_valid), .stall_up (prep_stall),
    .num (prep_num), .den (prep_den), .neg (prep_neg), .sing (prep_sing),
    .valid_dn (inv_valid), .stall_dn (inv_stall),
    .res (inv)
  );

endmodule

@@ design/mi3_checker.sv @@
// Port-level checks for matrix_inverse_3x3, bound onto the top level.
// Depends on mi3_pkg and matrix_inverse_3x3_defines.svh.
`include "matrix_inverse_3x3_defines.svh"

module mi3_checker import mi3_pkg::*; (
  input logic clk,
  input logic rst,
  input logic mat_valid,
  input logic mat_stall,
  input mat_t mat,
  input logic inv_valid,
  input logic inv_stall,
  input inv_t inv
);

  // no result beat straight out of reset
  `MI3_ALWAYS(a_rst_empty, rst, !inv_valid)
  // a waiting result beat stays put
  `MI3_NEXT(a_out_hold, inv_valid && inv_stall, inv_valid && $stable(inv))
  // a stalled input beat stays put
  `MI3_NEXT(a_in_hold, mat_valid && mat_stall, mat_valid && $stable(mat))
  // input backs up only when the whole pipe is full and the output is held
  `MI3_IMPL(a_stall_src, mat_stall, inv_valid && inv_stall)
  // singular beats carry zero elements; the diagonal, inv_01, inv_10 and inv_12 are checked
  `MI3_IMPL(a_sing_zero, inv_valid && inv.singular,
            inv.inv_00 == '0 && inv.inv_11 == '0 && inv.inv_22 == '0 &&
            inv.inv_01 == '0 && inv.inv_10 == '0 && inv.inv_12 == '0)

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk, .rst, .mat_valid, .mat_stall, .mat,
  .inv_valid, .inv_stall, .inv
);

@@ dv/tb_top.sv @@
// Self-checking testbench for matrix_inverse_3x3: directed table, then random phases.
// Expected results come from an exact wide-integer adjugate/division predictor.
// Depends on mi3_pkg (mat_t, inv_t, elem_t, THR_W) and the block under test.
module tb_top;
  import mi3_pkg::*;

  localparam int WW        = 256;
  localparam int CYCLE_MAX = 1000000;
  localparam int TAIL      = 60;   // beyond the pipeline depth
  localparam elem_t ONE    = 32'sh0001_0000;
  localparam elem_t EMAX   = 32'sh7fff_ffff;
  localparam elem_t EMIN   = 32'sh8000_0000;
  // cofactor operand indexes: adj[k] = a[p]*a[q] - a[s]*a[t]
  localparam int MINOR [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef logic signed [WW-1:0] wide_t;

  typedef struct {
    elem_t e [9];
    bit    known;
    inv_t  res;
  } drow_t;

  logic             clk;
  logic             rst;
  logic             mat_valid;
  logic             mat_stall;
  mat_t             mat;
  logic             inv_valid;
  logic             inv_stall;
  inv_t             inv;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data;

  inv_t             pending_inv [$];
  logic [THR_W-1:0] threshold;
  int               errors;
  int               cycles;
  bit               calm;

  matrix_inverse_3x3 uut (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall),
    .mat       (mat),
    .inv_valid (inv_valid),
    .inv_stall (inv_stall),
    .inv       (inv),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic inv_t invert_matrix(mat_t m, logic [THR_W-1:0] thr);
    wide_t a [9];
    wide_t adj [9];
    wide_t det, mag_det, mag_adj, lim, q;
    elem_t el [9];
    inv_t  r;
    bit    neg;
    a[0] = m.a00; a[1] = m.a01; a[2] = m.a02;
    a[3] = m.a10; a[4] = m.a11; a[5] = m.a12;
    a[6] = m.a20; a[7] = m.a21; a[8] = m.a22;
    for (int k = 0; k < 9; k++)
      adj[k] = a[MINOR[k][0]] * a[MINOR[k][1]] - a[MINOR[k][2]] * a[MINOR[k][3]];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    mag_det = det < 0 ? -det : det;
    lim = wide_t'({1'b0, thr}) <<< 32;
    r = '0;
    if (det == 0 || mag_det < lim) begin
      r.singular = 1'b1;
      return r;
    end
    for (int k = 0; k < 9; k++) begin
      neg = (adj[k] < 0) != (det < 0);
      mag_adj = adj[k] < 0 ? -adj[k] : adj[k];
      // round half away from zero on magnitudes
      q = ((mag_adj <<< 33) + mag_det) / (mag_det <<< 1);
      if (neg) begin
        if (q > 64'sd2147483648) q = 64'sd2147483648;
        el[k] = elem_t'(-q);
      end else begin
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        el[k] = elem_t'(q);
      end
    end
    r.inv_00 = el[0]; r.inv_01 = el[1]; r.inv_02 = el[2];
    r.inv_10 = el[3]; r.inv_11 = el[4]; r.inv_12 = el[5];
    r.inv_20 = el[6]; r.inv_21 = el[7]; r.inv_22 = el[8];
    r.singular = 1'b0;
    return r;
  endfunction

  function automatic mat_t pack_matrix(elem_t e [9]);
    return '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic elem_t rand_elem(int flavor);
    case (flavor)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(0, 6)) == 0 ? EMIN : EMAX;
      2: return elem_t'($urandom_range(0, 15));
      default: return elem_t'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endcase
  endfunction

  // output side: check every beat, stall at random
  always @(posedge clk) begin
    inv_t exp_inv;
    elem_t got [10];
    elem_t want [10];
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("FAIL matrix_inverse_3x3");
      $finish;
    end
    if (!rst && inv_valid && !inv_stall) begin
      if (pending_inv.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, inv);
        errors++;
      end else begin
        exp_inv = pending_inv.pop_front();
        got  = '{inv.inv_00, inv.inv_01, inv.inv_02, inv.inv_10, inv.inv_11,
                 inv.inv_12, inv.inv_20, inv.inv_21, inv.inv_22, elem_t'(inv.singular)};
        want = '{exp_inv.inv_00, exp_inv.inv_01, exp_inv.inv_02, exp_inv.inv_10,
                 exp_inv.inv_11, exp_inv.inv_12, exp_inv.inv_20, exp_inv.inv_21,
                 exp_inv.inv_22, elem_t'(exp_inv.singular)};
        for (int f = 0; f < 10; f++)
          if (got[f] !== want[f]) begin
            $display("%0t: field %0d (9 = singular) expected %h actual %h",
                     $time, f, want[f], got[f]);
            errors++;
          end
      end
    end
    inv_stall <= rst ? 1'b0 : (!calm && $urandom_range(0, 99) < 25);
  end

  task automatic send_matrix(mat_t m, bit known, inv_t res);
    inv_t pred;
    mat <= m;
    mat_valid <= 1'b1;
    do @(posedge clk); while (mat_stall);
    pred = invert_matrix(m, threshold);
    if (known && pred !== res) begin
      $display("%0t: table entry disagrees, expected %h predicted %h", $time, res, pred);
      errors++;
    end
    pending_inv.push_back(known ? res : pred);
    begin
      int g;
      g = idle_len();
      if (g > 0) begin
        mat_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    mat_valid <= 1'b0;
    while (pending_inv.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = v;
  endtask

  task automatic random_phase(int n);
    elem_t e [9];
    int    flavor;
    int    kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      flavor = kind < 55 ? 3 : kind < 80 ? 0 : kind < 90 ? 2 : 1;
      for (int k = 0; k < 9; k++)
        e[k] = ($urandom_range(0, 9) == 0) ? rand_elem($urandom_range(0, 3))
                                            : rand_elem(flavor);
      // some rank-deficient ones: copy a row
      if ($urandom_range(0, 19) == 0)
        for (int c = 0; c < 3; c++) e[6 + c] = e[c];
      calm = (i % 200) < 30;
      send_matrix(pack_matrix(e), 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  initial begin
    drow_t table_rows [$];
    drow_t row;
    inv_t  unit_inv;
    inv_t  half_inv;
    inv_t  sing;
    logic [THR_W-1:0] settings [6];

    rst       = 1'b1;
    mat_valid = 1'b0;
    mat       = '0;
    inv_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    errors    = 0;
    cycles    = 0;
    calm      = 1'b0;
    threshold = 31'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sing = '0;
    sing.singular = 1'b1;
    unit_inv = '0;
    unit_inv.inv_00 = ONE; unit_inv.inv_11 = ONE; unit_inv.inv_22 = ONE;
    half_inv = '0;
    half_inv.inv_00 = 32'sh8000; half_inv.inv_11 = 32'sh8000; half_inv.inv_22 = 32'sh8000;

    // identity, zero, doubled identity
    row.e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}; row.known = 1; row.res = unit_inv;
    table_rows.push_back(row);
    row.e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; row.res = sing;
    table_rows.push_back(row);
    row.e = '{2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE}; row.res = half_inv;
    table_rows.push_back(row);
    // all-max and all-min: equal rows, zero determinant
    row.e = '{EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX}; row.res = sing;
    table_rows.push_back(row);
    row.e = '{EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN}; row.res = sing;
    table_rows.push_back(row);
    // one-lsb diagonal: tiny nonzero determinant, below reset threshold
    row.e = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; row.res = sing;
    table_rows.push_back(row);
    // remaining rows checked by the predictor
    row.known = 0;
    row.e = '{EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN}; table_rows.push_back(row);
    row.e = '{EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX}; table_rows.push_back(row);
    row.e = '{EMAX, EMIN, 0, EMIN, EMAX, 0, 0, 0, ONE}; table_rows.push_back(row);
    row.e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}; table_rows.push_back(row);
    row.e = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0}; table_rows.push_back(row);
    row.e = '{3 * ONE, ONE, 0, 0, 3 * ONE, ONE, ONE, 0, 3 * ONE}; table_rows.push_back(row);
    row.e = '{256, 0, 0, 0, 256, 0, 0, 0, 256}; table_rows.push_back(row);
    row.e = '{EMAX, 1, 0, 0, EMIN, 1, 1, 0, EMAX}; table_rows.push_back(row);
    row.e = '{7, -3, 5, 2, 11, -13, -1, 4, 9}; table_rows.push_back(row);
    foreach (table_rows[i]) send_matrix(pack_matrix(table_rows[i].e), table_rows[i].known,
                                        table_rows[i].res);
    drain_results();

    // threshold zero: tiny determinants become regular and saturate
    write_threshold(31'd0);
    foreach (table_rows[i]) send_matrix(pack_matrix(table_rows[i].e), 1'b0, '0);
    row.e = '{1, 0, 0, 0, -1, 0, 0, 0, 1};
    send_matrix(pack_matrix(row.e), 1'b0, '0);
    drain_results();

    settings = '{31'd1, 31'd0, 31'h7fff_ffff, 31'd4, 31'd0, 31'd1};
    settings[4] = 31'($urandom_range(0, 32'h7fff_ffff));
    foreach (settings[s]) begin
      write_threshold(settings[s]);
      random_phase(250);
      drain_results();
    end

    if (errors == 0)
      $display("PASS matrix_inverse_3x3");
    else
      $display("FAIL matrix_inverse_3x3");
    $finish;
  end
endmodule
